[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the shader core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/ags_pkg.sv]
// ----------------------------------------------------------------------------
// Alpha gradient shader package
// Shared constants, codes and types of the alpha gradient shader core.
// ----------------------------------------------------------------------------
package ags_pkg;

	// Largest frame dimension; larger programmed sizes saturate to this.
	localparam int unsigned MAX_DIM = 4096;

	// Register field widths.
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned INDEX_W = 3;

	// Pipeline latency from an accepted start to the result strobe.
	localparam int unsigned LATENCY = 9;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_SHADE_MODE   = 3'd0;
	localparam logic [INDEX_W-1:0] REG_BASE_ALPHA   = 3'd1;
	localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
	localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ALPHA_LANE   = 3'd4;

	// Shading mode codes; the unused codes behave as the constant mode.
	localparam logic [2:0] MODE_VFADE  = 3'd0;
	localparam logic [2:0] MODE_SLOPE  = 3'd1;
	localparam logic [2:0] MODE_CONST  = 3'd2;
	localparam logic [2:0] MODE_HFADE  = 3'd3;
	localparam logic [2:0] MODE_HFADE5 = 3'd4;
	localparam logic [2:0] MODE_RAMP   = 3'd5;

	// Zone of the three-zone ramp in which a column falls.
	typedef enum logic [1:0] {
		ZONE_LOW,
		ZONE_MID,
		ZONE_HIGH
	} zone_t;

endpackage

[rtl/alpha_gradient_shader_core.sv]
// ----------------------------------------------------------------------------
// Alpha gradient shader core
// Scales the alpha byte of each pixel by a positional gradient factor.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock: busy is always low, so a transaction is
// accepted at every edge where start is high. Each result appears on pixel_out
// for exactly one cycle, marked by done; the receiver cannot stall, so results
// must be captured when done is high. In the nine-stage pipeline, the gradient
// divider resolves three quotient bits in each of three stages. Configuration
// should only be written while no transaction is in flight.
`include "assert_macros.svh"

module alpha_gradient_shader_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ags_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [ags_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         start,
	output logic                         busy,
	input  logic [31:0]                  pixel_in,
	input  logic [11:0]                  row,
	input  logic [11:0]                  col,
	output logic                         done,
	output logic [31:0]                  pixel_out
);
	import ags_pkg::*;

	// Configuration registers.
	logic [2:0]       shade_mode_q;
	logic [7:0]       base_alpha_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [DIM_W-1:0] frame_width_q;
	logic [1:0]       alpha_lane_q;

	// Valid bits of the pipeline.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, done_q;

	// Payload registers.
	logic [31:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6, pix_s7, pix_s8;
	logic [31:0] pixel_out_q;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	zone_t       zone_s1, zone_s2, zone_s3, zone_s4, zone_s5, zone_s6;
	logic [15:0] d_s1, d_s2, d_s3, d_s4, d_s5;
	logic [8:0]  m_s1;
	logic [15:0] mag_s1;
	logic [24:0] n_s2;
	logic [24:0] rem_s3, rem_s4, rem_s5;
	logic        sat_s3, sat_s4, sat_s5, sat_s6;
	logic [8:0]  q_s4, q_s5, q_s6;
	logic [7:0]  f_s7;
	logic [15:0] prod_s8;

	// Three restoring division steps, quotient bits top down to top-2.
	function automatic logic [33:0] div3(logic [24:0] rem_in, logic [8:0] q_in,
			logic [15:0] d, int unsigned top);
		logic [24:0] rem;
		logic [8:0]  q;
		logic [25:0] dsh;
		rem = rem_in;
		q   = q_in;
		for (int unsigned i = 0; i < 3; i++) begin
			dsh = 26'(d) << (top - i);
			if ({1'b0, rem} >= dsh) begin
				rem = rem - dsh[24:0];
				q[top - i] = 1'b1;
			end
		end
		return {q, rem};
	endfunction

	assign busy = 1'b0;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_mode_q   <= MODE_VFADE;
			base_alpha_q   <= 8'd255;
			frame_height_q <= 13'd512;
			frame_width_q  <= 13'd512;
			alpha_lane_q   <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHADE_MODE:   shade_mode_q   <= cfg_wdata[2:0];
				REG_BASE_ALPHA:   base_alpha_q   <= cfg_wdata[7:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_ALPHA_LANE:   alpha_lane_q   <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Effective frame dimensions: zero reads as one, oversize saturates.
	logic [DIM_W-1:0] h_eff, w_eff, w3;
	logic [DIM_W:0]   w3x2;
	logic [16:0]      h10, r11;
	logic [25:0]      w3_prod;

	always_comb begin
		if (frame_height_q == '0)
			h_eff = DIM_W'(1);
		else if (frame_height_q > DIM_W'(MAX_DIM))
			h_eff = DIM_W'(MAX_DIM);
		else
			h_eff = frame_height_q;
		if (frame_width_q == '0)
			w_eff = DIM_W'(1);
		else if (frame_width_q > DIM_W'(MAX_DIM))
			w_eff = DIM_W'(MAX_DIM);
		else
			w_eff = frame_width_q;
		h10     = 17'(h_eff) * 17'd10;
		r11     = 17'(row) * 17'd11;
		w3_prod = 26'(w_eff) * 26'd2731;
		w3      = w3_prod[25:13];
		w3x2    = {w3, 1'b0};
	end

	// Stage 1 operands: signed position term, multiplicand and divisor.
	logic signed [17:0] sdiff;
	logic [8:0]         m_c;
	logic [15:0]        d_c;
	zone_t              zone_c;
	logic [17:0]        mag_c;

	always_comb begin
		sdiff  = '0;
		m_c    = {1'b0, base_alpha_q};
		d_c    = 16'(w_eff);
		zone_c = ZONE_MID;
		case (shade_mode_q)
			MODE_VFADE: begin
				sdiff = $signed(18'(h_eff)) - $signed(18'(row));
				m_c   = 9'(base_alpha_q) + 9'd255;
				d_c   = 16'(h_eff);
			end
			MODE_SLOPE: begin
				sdiff = $signed({1'b0, h10}) - $signed({1'b0, r11});
				d_c   = h10[15:0];
			end
			MODE_HFADE, MODE_HFADE5: begin
				sdiff = $signed(18'(w_eff)) - $signed(18'(col));
			end
			MODE_RAMP: begin
				if (13'(col) < w3) begin
					sdiff  = $signed(18'(col));
					zone_c = ZONE_LOW;
				end else if (14'(col) > w3x2) begin
					sdiff  = $signed(18'(w_eff)) - $signed(18'(col));
					zone_c = ZONE_HIGH;
				end
			end
			default: ;
		endcase
		mag_c = sdiff[17] ? 18'(-sdiff) : 18'(sdiff);
	end

	// Stage 6 to 7: gradient factor from the quotient, clamped to 5..255.
	logic [8:0]         qm;
	logic signed [11:0] qsgn;
	logic signed [11:0] fs;
	logic [17:0]        p5;

	always_comb begin
		qm   = sat_s6 ? 9'h1FF : q_s6;
		qsgn = neg_s6 ? -$signed(12'(qm)) : $signed(12'(qm));
		p5   = 18'(qm) * 18'd205;
		case (shade_mode_q)
			MODE_VFADE:  fs = 12'sd50 + qsgn;
			MODE_SLOPE,
			MODE_HFADE:  fs = qsgn;
			MODE_HFADE5: fs = neg_s6 ? 12'sd0 : $signed(12'(p5[17:10]));
			MODE_RAMP: begin
				if (zone_s6 == ZONE_MID)
					fs = 12'sd100 + $signed(12'(base_alpha_q));
				else
					fs = 12'sd100 + qsgn * 12'sd3;
			end
			default:     fs = $signed(12'(base_alpha_q));
		endcase
	end

	// Stage 7 to 8: alpha byte times factor.
	logic [4:0] lane_sh;
	logic [7:0] pa;

	assign lane_sh = {alpha_lane_q, 3'b000};
	assign pa      = pix_s7[lane_sh +: 8];

	// Stage 8 to output: divide by 255 and merge the new alpha byte.
	logic [16:0] na_sum;
	logic [7:0]  na;

	assign na_sum = 17'(prod_s8) + 17'd1 + 17'(prod_s8[15:8]);
	assign na     = na_sum[15:8];

	// Valid bits move one stage per clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			done_q <= v_s8;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Stage 1: operands.
		pix_s1  <= pixel_in;
		neg_s1  <= sdiff[17];
		mag_s1  <= mag_c[15:0];
		m_s1    <= m_c;
		d_s1    <= d_c;
		zone_s1 <= zone_c;
		// Stage 2: numerator magnitude.
		pix_s2  <= pix_s1;
		neg_s2  <= neg_s1;
		n_s2    <= 25'(m_s1) * 25'(mag_s1);
		d_s2    <= d_s1;
		zone_s2 <= zone_s1;
		// Stage 3: overflow check of the nine-bit quotient.
		pix_s3  <= pix_s2;
		neg_s3  <= neg_s2;
		rem_s3  <= n_s2;
		sat_s3  <= {1'b0, n_s2} >= {1'b0, d_s2, 9'b0};
		d_s3    <= d_s2;
		zone_s3 <= zone_s2;
		// Stages 4 to 6: three quotient bits each.
		pix_s4  <= pix_s3;
		neg_s4  <= neg_s3;
		{q_s4, rem_s4} <= div3(rem_s3, 9'd0, d_s3, 8);
		sat_s4  <= sat_s3;
		d_s4    <= d_s3;
		zone_s4 <= zone_s3;
		pix_s5  <= pix_s4;
		neg_s5  <= neg_s4;
		{q_s5, rem_s5} <= div3(rem_s4, q_s4, d_s4, 5);
		sat_s5  <= sat_s4;
		d_s5    <= d_s4;
		zone_s5 <= zone_s4;
		pix_s6  <= pix_s5;
		neg_s6  <= neg_s5;
		q_s6    <= 9'(div3(rem_s5, q_s5, d_s5, 2) >> 25);
		sat_s6  <= sat_s5;
		zone_s6 <= zone_s5;
		// Stage 7: clamped factor.
		pix_s7  <= pix_s6;
		if (fs < 12'sd5)
			f_s7 <= 8'd5;
		else if (fs > 12'sd255)
			f_s7 <= 8'd255;
		else
			f_s7 <= fs[7:0];
		// Stage 8: product.
		pix_s8  <= pix_s7;
		prod_s8 <= 16'(pa) * 16'(f_s7);
		// Output register.
		pixel_out_q <= (pix_s8 & ~(32'hFF << lane_sh)) | (32'(na) << lane_sh);
	end

	assign done      = done_q;
	assign pixel_out = pixel_out_q;

	// Checks.
	`ASSERT_IMPLIES(a_done_from_start, clk, arst_n, done, $past(start, LATENCY), "done without a matching start")
	`ASSERT_IMPLIES(a_factor_range, clk, arst_n, v_s8, (f_s7 >= 8'd5), "gradient factor below five")
	`ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "busy raised by a fully pipelined core")

endmodule
